// ----- design/modular_exponentiation_assert.svh -----
// Assertion macros for the modular exponentiation block.
// Included by the top level; no other dependencies.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH
`ifndef SYNTH
`define MODEXP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MODEXP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MODEXP_ASSERT_SAME(lbl, ante, cons)
`define MODEXP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/modexp_pkg.sv -----
// Package for the modular exponentiation block: operation tags,
// pipeline control struct and sequencer states. No dependencies.
package modexp_pkg;

    typedef enum logic [1:0] {
        OP_RED,
        OP_MUL,
        OP_SQR
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_ISSUE_MUL,
        ST_ISSUE_SQR,
        ST_WAIT,
        ST_DONE
    } state_t;

endpackage

// ----- design/modexp_cell.sv -----
// One cell of the modular multiplier chain: handles one bit of the x operand.
// Depends on modexp_pkg.
module modexp_cell #(
    parameter int MOD_BITS = 30,
    parameter int BIT_IDX  = 29
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [MOD_BITS-1:0]   modulus,
    input  modexp_pkg::ctl_t      ctl_in,
    input  logic [MOD_BITS-1:0]   x_in,
    input  logic [MOD_BITS-1:0]   y_in,
    input  logic [MOD_BITS-1:0]   r_in,
    output modexp_pkg::ctl_t      ctl_out,
    output logic [MOD_BITS-1:0]   x_out,
    output logic [MOD_BITS-1:0]   y_out,
    output logic [MOD_BITS-1:0]   r_out
);

    logic [MOD_BITS+1:0] t;
    logic [MOD_BITS+1:0] m1;
    logic [MOD_BITS+1:0] m2;
    logic [MOD_BITS-1:0] r_next;
    modexp_pkg::ctl_t    ctl_reg;
    logic [MOD_BITS-1:0] x_reg;
    logic [MOD_BITS-1:0] y_reg;
    logic [MOD_BITS-1:0] r_reg;

    // The partial result doubles and adds y when the bit is set; it stays
    // below three times the modulus, so at most two subtractions are needed.
    always_comb
    begin
        m1 = {2'b00, modulus};
        m2 = {1'b0, modulus, 1'b0};
        t  = {1'b0, r_in, 1'b0} + (x_in[BIT_IDX] ? {2'b00, y_in} : '0);
        if (t >= m2)
        begin
            r_next = MOD_BITS'(t - m2);
        end
        else if (t >= m1)
        begin
            r_next = MOD_BITS'(t - m1);
        end
        else
        begin
            r_next = MOD_BITS'(t);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '{valid: 1'b0, op: modexp_pkg::OP_RED};
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_in;
        y_reg <= y_in;
        r_reg <= r_next;
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign r_out   = r_reg;

endmodule

// ----- design/modexp_chain.sv -----
// Row of multiplier cells computing x * y mod modulus, most significant bit
// first, one cell per bit. Depends on modexp_pkg and modexp_cell.
module modexp_chain #(
    parameter int MOD_BITS = 30
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [MOD_BITS-1:0] modulus,
    input  modexp_pkg::ctl_t    ctl_in,
    input  logic [MOD_BITS-1:0] x_in,
    input  logic [MOD_BITS-1:0] y_in,
    output modexp_pkg::ctl_t    ctl_out,
    output logic [MOD_BITS-1:0] result
);

    modexp_pkg::ctl_t    ctl_s [MOD_BITS+1];
    logic [MOD_BITS-1:0] x_s   [MOD_BITS+1];
    logic [MOD_BITS-1:0] y_s   [MOD_BITS+1];
    logic [MOD_BITS-1:0] r_s   [MOD_BITS+1];

    assign ctl_s[0] = ctl_in;
    assign x_s[0]   = x_in;
    assign y_s[0]   = y_in;
    assign r_s[0]   = '0;

    for (genvar i = 0; i < MOD_BITS; i++)
    begin : g_cell
        modexp_cell #(
            .MOD_BITS (MOD_BITS),
            .BIT_IDX  (MOD_BITS - 1 - i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .modulus (modulus),
            .ctl_in  (ctl_s[i]),
            .x_in    (x_s[i]),
            .y_in    (y_s[i]),
            .r_in    (r_s[i]),
            .ctl_out (ctl_s[i+1]),
            .x_out   (x_s[i+1]),
            .y_out   (y_s[i+1]),
            .r_out   (r_s[i+1])
        );
    end

    assign ctl_out = ctl_s[MOD_BITS];
    assign result  = r_s[MOD_BITS];

endmodule

// ----- design/modular_exponentiation.sv -----
// Top level of the modular exponentiation block: sequencer and operand
// registers. Depends on modexp_pkg, modexp_chain and the assertion header.
//
//   channel   handshake          payload
//   input     start / busy       base, exponent
//   result    done (strobe)      power
//   config    modulus_we         modulus_wdata
//
// Done follows the accepted start once the base has been reduced and, for each
// exponent bit, a multiply and a square have passed through the multiplier
// chain; the next item can be accepted in the cycle after done. A modulus
// below two gives a result of zero in the cycle right after start. Reset loads
// the modulus with 1000000007 and leaves the block idle. The receiver cannot
// stall: done is high for one cycle and busy stays high until then.
`include "modular_exponentiation_assert.svh"

module modular_exponentiation #(
    parameter int EXP_BITS = 32,
    parameter int MOD_BITS = 30
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [MOD_BITS-1:0] base,
    input  logic [EXP_BITS-1:0] exponent,
    output logic                done,
    output logic [MOD_BITS-1:0] power,
    input  logic                modulus_we,
    input  logic [MOD_BITS-1:0] modulus_wdata
);

    localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(1000000007);
    localparam int CNT_W = $clog2(EXP_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(EXP_BITS - 1);

    modexp_pkg::state_t  state_reg, state_next;
    logic [MOD_BITS-1:0] modulus_reg;
    logic [MOD_BITS-1:0] base_reg, base_next;
    logic [EXP_BITS-1:0] e_reg, e_next;
    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [MOD_BITS-1:0] sq_reg, sq_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                small_mod;

    modexp_pkg::ctl_t    issue_ctl;
    logic [MOD_BITS-1:0] issue_x;
    logic [MOD_BITS-1:0] issue_y;
    modexp_pkg::ctl_t    res_ctl;
    logic [MOD_BITS-1:0] res;

    assign small_mod = (modulus_reg < MOD_BITS'(2));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            modexp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = small_mod ? modexp_pkg::ST_DONE : modexp_pkg::ST_REDUCE;
                end
            end
            modexp_pkg::ST_REDUCE:    state_next = modexp_pkg::ST_WAIT;
            modexp_pkg::ST_ISSUE_MUL: state_next = modexp_pkg::ST_ISSUE_SQR;
            modexp_pkg::ST_ISSUE_SQR: state_next = modexp_pkg::ST_WAIT;
            modexp_pkg::ST_WAIT:
            begin
                if (res_ctl.valid && res_ctl.op == modexp_pkg::OP_RED)
                begin
                    state_next = modexp_pkg::ST_ISSUE_MUL;
                end
                else if (res_ctl.valid && res_ctl.op == modexp_pkg::OP_SQR)
                begin
                    state_next = (cnt_reg == CNT_LAST) ? modexp_pkg::ST_DONE
                                                       : modexp_pkg::ST_ISSUE_MUL;
                end
            end
            modexp_pkg::ST_DONE:      state_next = modexp_pkg::ST_IDLE;
            default:                  state_next = modexp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        issue_ctl = '{valid: 1'b0, op: modexp_pkg::OP_RED};
        issue_x   = acc_reg;
        issue_y   = sq_reg;
        case (state_reg)
            modexp_pkg::ST_REDUCE:
            begin
                issue_ctl = '{valid: 1'b1, op: modexp_pkg::OP_RED};
                issue_x   = base_reg;
                issue_y   = MOD_BITS'(1);
            end
            modexp_pkg::ST_ISSUE_MUL:
            begin
                issue_ctl = '{valid: 1'b1, op: modexp_pkg::OP_MUL};
            end
            modexp_pkg::ST_ISSUE_SQR:
            begin
                issue_ctl = '{valid: 1'b1, op: modexp_pkg::OP_SQR};
                issue_x   = sq_reg;
            end
            default:
            begin
                issue_ctl = '{valid: 1'b0, op: modexp_pkg::OP_RED};
            end
        endcase
    end

    always_comb
    begin
        base_next = base_reg;
        e_next    = e_reg;
        acc_next  = acc_reg;
        sq_next   = sq_reg;
        cnt_next  = cnt_reg;
        if (state_reg == modexp_pkg::ST_IDLE && start)
        begin
            base_next = base;
            e_next    = exponent;
            acc_next  = small_mod ? '0 : MOD_BITS'(1);
            cnt_next  = '0;
        end
        else if (state_reg == modexp_pkg::ST_WAIT && res_ctl.valid)
        begin
            case (res_ctl.op)
                modexp_pkg::OP_RED: sq_next = res;
                modexp_pkg::OP_MUL:
                begin
                    if (e_reg[0])
                    begin
                        acc_next = res;
                    end
                end
                modexp_pkg::OP_SQR:
                begin
                    sq_next  = res;
                    e_next   = e_reg >> 1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                default:
                begin
                    sq_next = sq_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= modexp_pkg::ST_IDLE;
            modulus_reg <= MOD_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (modulus_we)
            begin
                modulus_reg <= modulus_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        e_reg    <= e_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        cnt_reg  <= cnt_next;
    end

    modexp_chain #(
        .MOD_BITS (MOD_BITS)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .ctl_in  (issue_ctl),
        .x_in    (issue_x),
        .y_in    (issue_y),
        .ctl_out (res_ctl),
        .result  (res)
    );

    assign busy  = (state_reg != modexp_pkg::ST_IDLE);
    assign done  = (state_reg == modexp_pkg::ST_DONE);
    assign power = acc_reg;

    `MODEXP_ASSERT_NEXT(a_done_single, done, !done)
    `MODEXP_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `MODEXP_ASSERT_SAME(a_chain_busy, res_ctl.valid, busy)
    `MODEXP_ASSERT_SAME(a_power_range, done && !small_mod, power < modulus_reg)

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for modular_exponentiation: random and directed items
// are checked against a square-and-multiply predictor. Depends on the RTL only.
`timescale 1ns / 100ps

module tb_top;

    localparam int EB = 32;
    localparam int MB = 30;
    localparam longint unsigned CYCLE_LIMIT = 6000000;

    typedef struct {
        logic [MB-1:0] base;
        logic [EB-1:0] exponent;
    } exp_item_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic [MB-1:0] base = '0;
    logic [EB-1:0] exponent = '0;
    logic          done;
    logic [MB-1:0] power;
    logic          modulus_we = 1'b0;
    logic [MB-1:0] modulus_wdata = '0;

    exp_item_t     pending_items[$];
    logic [MB-1:0] expected_powers[$];
    logic [MB-1:0] cur_modulus = 30'd1000000007;
    int            errors = 0;
    int            checked = 0;
    int            burst_left = 0;
    int            gap_left = 0;
    longint unsigned cycles = 0;

    modular_exponentiation #(.EXP_BITS(EB), .MOD_BITS(MB)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .base(base),
        .exponent(exponent), .done(done), .power(power),
        .modulus_we(modulus_we), .modulus_wdata(modulus_wdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [MB-1:0] predict_power(logic [MB-1:0] b, logic [EB-1:0] e,
                                                    logic [MB-1:0] m);
        longint unsigned md;
        longint unsigned sq;
        longint unsigned acc;
        md = m;
        if (md < 2)
            return '0;
        sq = longint'(b) % md;
        acc = 1;
        for (int i = 0; i < EB; i++)
        begin
            if (e[i])
                acc = (acc * sq) % md;
            sq = (sq * sq) % md;
        end
        return acc[MB-1:0];
    endfunction

    always @(posedge clk)
    begin
        logic next_start;
        exp_item_t it;
        next_start = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
                expected_powers = {expected_powers,
                                   predict_power(base, exponent, cur_modulus)};
            if (!start || !busy)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_items.size() > 0)
                begin
                    it = pending_items.pop_front();
                    base <= it.base;
                    exponent <= it.exponent;
                    next_start = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? 20 : $urandom_range(1, 6);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
            end
            else
                next_start = 1'b1;
        end
        start <= next_start;
    end

    always @(posedge clk)
    begin
        logic [MB-1:0] want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_powers.size());
            $display("*** FAILED ***");
            $finish;
        end
        if (rst_n && done)
        begin
            if (expected_powers.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual power %0d",
                         $time, power);
                errors++;
            end
            else
            begin
                want = expected_powers.pop_front();
                checked++;
                if (power !== want)
                begin
                    $display("%0t: power mismatch, expected %0d, actual %0d",
                             $time, want, power);
                    errors++;
                end
            end
        end
    end

    task automatic add_item(logic [MB-1:0] b, logic [EB-1:0] e);
        exp_item_t it;
        it.base = b;
        it.exponent = e;
        pending_items = {pending_items, it};
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || start || expected_powers.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_modulus(logic [MB-1:0] m);
        wait_idle();
        modulus_we <= 1'b1;
        modulus_wdata <= m;
        @(posedge clk);
        cur_modulus = m;
        modulus_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic add_random(int n);
        logic [EB-1:0] e;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0: e = $urandom_range(0, 16);
                1: e = $urandom() >> $urandom_range(0, 31);
                default: e = $urandom();
            endcase
            if ($urandom_range(0, 9) == 0)
                add_item(MB'(cur_modulus + $urandom_range(0, 3)), e);
            else
                add_item(MB'($urandom()), e);
        end
    endtask

    initial
    begin
        int mods[$];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_item('0, '0);
        add_item('1, '0);
        add_item('1, '1);
        add_item('0, 32'd5);
        add_item(30'd2, 32'd1);
        add_item(30'd1000000007, 32'd3);
        add_item(30'd1000000008, 32'd7);
        add_item(30'd1000000006, 32'd2);
        add_item(30'd123456789, 32'h8000_0000);
        add_item(30'h2AAA_AAAA, 32'h5555_5555);
        add_item(30'h1555_5555, 32'hAAAA_AAAA);
        add_random(260);

        mods = '{30'h3FFF_FFFF, 2, 0, 1, 3, 30'h2000_0000, 65537, 1000000007};
        foreach (mods[k])
        begin
            write_modulus(MB'(mods[k]));
            add_item('0, '0);
            add_item('1, '1);
            add_item(MB'(mods[k]), 32'd9);
            if (mods[k] < 4)
                add_random(60);
            else
                add_random(110);
        end
        write_modulus(MB'($urandom_range(4, 30'h3FFF_FFFF)));
        add_random(120);

        wait_idle();
        repeat (1100) @(posedge clk);
        $display("Checked %0d results over ten modulus settings, including moduli 0, 1, 2",
                 checked);
        $display("and 2^30-1, with bursty start traffic and full-range base and exponent.");
        if (errors == 0 && expected_powers.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
